### rtl/core/mvt_pkg.sv
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform.
// Holds register indexes, reset columns and the pipeline control struct.
// No dependencies.
`default_nettype none

package mvt_pkg;

    // Number of matrix columns, vector components and output lanes
    localparam int NUM_COLS  = 4;
    localparam int NUM_LANES = 4;

    // Width of one column register
    localparam int CFG_W = 64;

    // Column register indexes
    typedef enum logic [1:0] {
        CFG_COL_X     = 2'd0,
        CFG_COL_Y     = 2'd1,
        CFG_COL_Z     = 2'd2,
        CFG_COL_TRANS = 2'd3
    } t_cfg_idx;

    // Reset columns: identity matrix in Q3.12
    localparam logic [CFG_W-1:0] RST_COL_X     = 64'h0000_0000_0000_1000;
    localparam logic [CFG_W-1:0] RST_COL_Y     = 64'h0000_0000_1000_0000;
    localparam logic [CFG_W-1:0] RST_COL_Z     = 64'h0000_1000_0000_0000;
    localparam logic [CFG_W-1:0] RST_COL_TRANS = 64'h1000_0000_0000_0000;

    // Load enables for the lane pipeline stages
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_pipe_ctl;

endpackage

`default_nettype wire

### rtl/core/mvt_vec_if.sv
// mvt_vec_if: input vector channel (valid/ready plus four components).
// Depends on nothing; width set by DATA_WIDTH.
`default_nettype none

interface mvt_vec_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
    logic signed [DATA_WIDTH-1:0] vec_w;

    modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

`default_nettype wire

### rtl/core/mvt_res_if.sv
// mvt_res_if: result channel (valid/ready, four components, saturation flag).
// Depends on nothing; width set by DATA_WIDTH.
`default_nettype none

interface mvt_res_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic signed [DATA_WIDTH-1:0] out_w;
    logic                         saturated;

    modport source (output valid, out_x, out_y, out_z, out_w, saturated,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, saturated,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/mvt_lane.sv
// mvt_lane: one output component: four products, sum with rounding,
// then shift and saturate. Depends on mvt_pkg.
`default_nettype none

module mvt_lane #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  wire                               i_clk,
    input  mvt_pkg::t_pipe_ctl                i_ctl,
    input  logic signed [DATA_WIDTH-1:0]      i_coef [mvt_pkg::NUM_COLS],
    input  logic signed [DATA_WIDTH-1:0]      i_vec  [mvt_pkg::NUM_COLS],
    output logic signed [DATA_WIDTH-1:0]      o_res,
    output logic                              o_sat
);
    import mvt_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    // Sum width; wraps at 64 bits like a 64-bit accumulator would
    localparam int SW = (2 * DATA_WIDTH + 3 > 64) ? 64 : 2 * DATA_WIDTH + 3;
    localparam logic signed [SW-1:0] RND = SW'((2 ** FRAC_BITS) >> 1);
    localparam logic signed [SW-1:0] HI  =
        SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LO  = -HI - SW'(1);

    logic signed [PW-1:0] r_prod [NUM_COLS];
    logic signed [PW-1:0] n_prod [NUM_COLS];
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;
    logic signed [SW-1:0] w_shift;

    // Multiply each coefficient by its vector component
    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            n_prod[c] = i_coef[c] * i_vec[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_prod <= n_prod;
        end
    end

    // Add the products and the rounding half
    always_comb begin
        n_sum = RND;
        for (int c = 0; c < NUM_COLS; c++) begin
            n_sum = n_sum + SW'(r_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sum <= n_sum;
        end
    end

    // Floor shift, then clamp to the output range
    assign w_shift = r_sum >>> FRAC_BITS;

    always_comb begin
        if (w_shift > HI) begin
            o_res = HI[DATA_WIDTH-1:0];
            o_sat = 1'b1;
        end else if (w_shift < LO) begin
            o_res = LO[DATA_WIDTH-1:0];
            o_sat = 1'b1;
        end else begin
            o_res = w_shift[DATA_WIDTH-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mvt_merge.sv
// mvt_merge: output register that gathers the four lane results and
// combines their saturation flags. Depends on mvt_pkg.
`default_nettype none

module mvt_merge #(
    parameter int DATA_WIDTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    input  wire                               i_out_ready,
    input  logic signed [DATA_WIDTH-1:0]      i_res [mvt_pkg::NUM_LANES],
    input  logic        [mvt_pkg::NUM_LANES-1:0] i_sat,
    output logic                              o_ready,
    output logic                              o_valid,
    output logic signed [DATA_WIDTH-1:0]      o_res [mvt_pkg::NUM_LANES],
    output logic                              o_sat
);
    import mvt_pkg::*;

    logic                          r_valid;
    logic signed [DATA_WIDTH-1:0]  r_res [NUM_LANES];
    logic                          r_sat;

    // Take a new result when empty or when the held one leaves
    assign o_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload; flag any clamped lane
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
            r_sat <= |i_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_sat   = r_sat;

endmodule

`default_nettype wire

### rtl/core/matrix4_vector_transform.sv
// matrix4_vector_transform: top level, column registers, four parallel lanes
// and the merging output stage. Depends on mvt_pkg, mvt_vec_if, mvt_res_if,
// mvt_lane and mvt_merge.
//
//   channel   dir  payload                                 handshake
//   i_vec     in   vec_x, vec_y, vec_z, vec_w              valid/ready
//   o_res     out  out_x, out_y, out_z, out_w, saturated   valid/ready
//   i_cfg_*   in   index, 64-bit column                    write enable only
//
// Input transactions pass the multiply register, then the sum register with
// rounding, then shift/saturate into the output register. One transaction
// per cycle unless o_res stalls; sixteen multipliers, four per lane.
// Reset is synchronous and clears stage valids; columns return to identity.
// A stall on o_res fills empty stages first, then holds i_vec.ready low.
`default_nettype none

module matrix4_vector_transform #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  mvt_pkg::t_cfg_idx             i_cfg_idx,
    input  wire [mvt_pkg::CFG_W-1:0]      i_cfg_data,
    mvt_vec_if.sink                       i_vec,
    mvt_res_if.source                     o_res
);
    import mvt_pkg::*;

    logic [CFG_W-1:0]             r_col [NUM_COLS];
    logic                         r_v_mul;
    logic                         r_v_sum;
    logic                         w_rdy_mul;
    logic                         w_rdy_sum;
    logic                         w_rdy_out;
    t_pipe_ctl                    w_ctl;
    logic signed [DATA_WIDTH-1:0] w_vec  [NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_coef [NUM_LANES][NUM_COLS];
    logic signed [DATA_WIDTH-1:0] w_res  [NUM_LANES];
    logic        [NUM_LANES-1:0]  w_sat;
    logic signed [DATA_WIDTH-1:0] w_out  [NUM_LANES];

    // Column registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= RST_COL_X;
            r_col[1] <= RST_COL_Y;
            r_col[2] <= RST_COL_Z;
            r_col[3] <= RST_COL_TRANS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COL_X:     r_col[0] <= i_cfg_data;
                CFG_COL_Y:     r_col[1] <= i_cfg_data;
                CFG_COL_Z:     r_col[2] <= i_cfg_data;
                CFG_COL_TRANS: r_col[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Split columns into lanes; lanes past bit 63 read as zero
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_coef
        for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
            assign w_coef[k][c] =
                DATA_WIDTH'({{CFG_W{1'b0}}, r_col[c]} >> (k * DATA_WIDTH));
        end
    end

    assign w_vec[0] = i_vec.vec_x;
    assign w_vec[1] = i_vec.vec_y;
    assign w_vec[2] = i_vec.vec_z;
    assign w_vec[3] = i_vec.vec_w;

    // Stage advance: a stage loads when empty or when it drains
    assign w_rdy_sum = !r_v_sum || w_rdy_out;
    assign w_rdy_mul = !r_v_mul || w_rdy_sum;
    assign w_ctl.en_mul = w_rdy_mul;
    assign w_ctl.en_sum = w_rdy_sum;
    assign i_vec.ready  = w_rdy_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
            r_v_sum <= 1'b0;
        end else begin
            if (w_rdy_mul) begin
                r_v_mul <= i_vec.valid;
            end
            if (w_rdy_sum) begin
                r_v_sum <= r_v_mul;
            end
        end
    end

    // One lane per output component
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        mvt_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_coef (w_coef[k]),
            .i_vec  (w_vec),
            .o_res  (w_res[k]),
            .o_sat  (w_sat[k])
        );
    end

    // Merge lanes into the output register
    mvt_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v_sum),
        .i_out_ready (o_res.ready),
        .i_res       (w_res),
        .i_sat       (w_sat),
        .o_ready     (w_rdy_out),
        .o_valid     (o_res.valid),
        .o_res       (w_out),
        .o_sat       (o_res.saturated)
    );

    assign o_res.out_x = w_out[0];
    assign o_res.out_y = w_out[1];
    assign o_res.out_z = w_out[2];
    assign o_res.out_w = w_out[3];

endmodule

`default_nettype wire

### test/tb.sv
// tb: self-checking bench for matrix4_vector_transform (4x4 Q3.12 matrix times vector).
// Drives vectors and column writes; checks each result, planned or predicted, by field.
// Depends on mvt_pkg, mvt_vec_if, mvt_res_if and the RTL under rtl/core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    localparam int DW          = 16;
    localparam int FRAC        = 12;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] w;
    } t_vec;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] w;
        logic                 sat;
    } t_transformed;

    // One row of the directed plan: a column write or a vector
    typedef struct {
        bit               is_write;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] col;
        t_vec             v;
        bit               typed;
        t_transformed     want;
    } t_plan_row;

    typedef enum {
        MAT_SMALL,
        MAT_RANDOM,
        MAT_MAX,
        MAT_MIN,
        MAT_ZERO,
        MAT_IDENT
    } t_mat_mode;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    t_cfg_idx         i_cfg_idx = CFG_COL_X;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             res_ready = 1'b0;

    mvt_vec_if #(.DATA_WIDTH(DW)) vec_if ();
    mvt_res_if #(.DATA_WIDTH(DW)) res_if ();

    assign res_if.ready = res_ready;

    matrix4_vector_transform #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_vec     (vec_if),
        .o_res     (res_if)
    );

    always #1 i_clk = ~i_clk;

    // Matrix copy kept in step with the column writes
    logic [CFG_W-1:0] ident_cols [NUM_COLS] = '{RST_COL_X, RST_COL_Y, RST_COL_Z, RST_COL_TRANS};
    logic [CFG_W-1:0] mat_col [NUM_COLS];

    t_transformed pending_results [$];
    t_transformed res_want;
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           stall_left = 0;
    bit           vec_burst = 1'b0;
    bit           res_burst = 1'b0;

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [DW-1:0] got, logic [DW-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, $signed(got),
                                      $signed(want)));
        end
    endtask

    // Exact sum of lane times component, round half up, shift, clamp
    function automatic t_transformed predict_result(t_vec v);
        longint signed        comp [NUM_COLS];
        longint signed        acc;
        longint signed        hi;
        longint signed        lo;
        logic signed [DW-1:0] lane;
        logic signed [DW-1:0] outs [NUM_LANES];
        logic                 sat;
        int                   k;
        int                   c;
        t_transformed         r;
        comp[0] = v.x;
        comp[1] = v.y;
        comp[2] = v.z;
        comp[3] = v.w;
        hi  = (64'sd1 <<< (DW - 1)) - 1;
        lo  = -hi - 1;
        sat = 1'b0;
        for (k = 0; k < NUM_LANES; k++) begin
            acc = 0;
            for (c = 0; c < NUM_COLS; c++) begin
                lane = mat_col[c][k*DW +: DW];
                acc += lane * comp[c];
            end
            if (FRAC > 0) begin
                acc = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
            end
            if (acc > hi) begin
                acc = hi;
                sat = 1'b1;
            end else if (acc < lo) begin
                acc = lo;
                sat = 1'b1;
            end
            outs[k] = acc[DW-1:0];
        end
        r.x   = outs[0];
        r.y   = outs[1];
        r.z   = outs[2];
        r.w   = outs[3];
        r.sat = sat;
        return r;
    endfunction

    function automatic int pick_gap(bit burst);
        int roll;
        if (burst) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic t_plan_row row_write(t_cfg_idx idx, logic [CFG_W-1:0] col);
        t_plan_row r;
        r          = '{idx: CFG_COL_X, default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.col      = col;
        return r;
    endfunction

    function automatic t_plan_row row_vec(int x, int y, int z, int w);
        t_plan_row r;
        r   = '{idx: CFG_COL_X, default: '0};
        r.v = '{x[DW-1:0], y[DW-1:0], z[DW-1:0], w[DW-1:0]};
        return r;
    endfunction

    function automatic t_plan_row row_typed(int x, int y, int z, int w,
                                            int ex, int ey, int ez, int ew, bit sat);
        t_plan_row r;
        r       = row_vec(x, y, z, w);
        r.typed = 1'b1;
        r.want  = '{ex[DW-1:0], ey[DW-1:0], ez[DW-1:0], ew[DW-1:0], sat};
        return r;
    endfunction

    function automatic logic [DW-1:0] random_component();
        int corner [5] = '{-32768, -1, 0, 1, 32767};
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            return DW'($urandom);
        end else if (roll < 8) begin
            return DW'($urandom_range(0, 12000) - 6000);
        end
        return DW'(corner[$urandom_range(0, 4)]);
    endfunction

    function automatic logic [CFG_W-1:0] random_column(t_mat_mode mode, int c);
        logic [CFG_W-1:0] col;
        int               k;
        col = '0;
        case (mode)
            MAT_SMALL: begin
                for (k = 0; k < NUM_LANES; k++) begin
                    col[k*DW +: DW] = DW'($urandom_range(0, 8192) - 4096);
                end
            end
            MAT_RANDOM: col = {$urandom, $urandom};
            MAT_MAX:    col = {NUM_LANES{16'h7FFF}};
            MAT_MIN:    col = {NUM_LANES{16'h8000}};
            MAT_ZERO:   col = '0;
            default:    col = ident_cols[c];
        endcase
        return col;
    endfunction

    // Drop valid and hold until every pending result has arrived
    task automatic wait_drained();
        vec_if.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_column(t_cfg_idx idx, logic [CFG_W-1:0] col);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = col;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        mat_col[idx] = col;
    endtask

    // Present one vector after a random gap, hold it until the transaction
    task automatic send_vector(t_vec v, bit typed, t_transformed want);
        int gap;
        gap = pick_gap(vec_burst);
        if (gap > 0) begin
            vec_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        vec_if.valid = 1'b1;
        vec_if.vec_x = v.x;
        vec_if.vec_y = v.y;
        vec_if.vec_z = v.z;
        vec_if.vec_w = v.w;
        @(posedge i_clk);
        while (!vec_if.ready) @(posedge i_clk);
        pending_results.push_back(typed ? want : predict_result(v));
        @(negedge i_clk);
    endtask

    // Result side: random stalls, ready changes at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_ready <= 1'b0;
            stall_left--;
        end else begin
            res_ready <= 1'b1;
            if (!res_burst && $urandom_range(0, 99) < 30) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
        end
    end

    // Check each result transaction against the oldest expectation; watch for hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with nothing pending");
                end else begin
                    res_want = pending_results.pop_front();
                    check_field("out_x", res_if.out_x, res_want.x);
                    check_field("out_y", res_if.out_y, res_want.y);
                    check_field("out_z", res_if.out_z, res_want.z);
                    check_field("out_w", res_if.out_w, res_want.w);
                    check_field("saturated", DW'(res_if.saturated), DW'(res_want.sat));
                end
            end
            if ((vec_if.valid && vec_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        t_plan_row dir_plan [$];
        t_vec      v;
        t_mat_mode mode;
        int        phase;
        int        n;
        int        c;

        vec_if.valid = 1'b0;
        vec_if.vec_x = '0;
        vec_if.vec_y = '0;
        vec_if.vec_z = '0;
        vec_if.vec_w = '0;
        mat_col      = ident_cols;

        dir_plan = '{
            // identity after reset: vector passes through
            row_typed(0, 0, 0, 0, 0, 0, 0, 0, 1'b0),
            row_typed(32767, -32768, 1, -1, 32767, -32768, 1, -1, 1'b0),
            row_typed(-32768, 32767, -1, 1, -32768, 32767, -1, 1, 1'b0),
            row_typed(-1, -1, -1, -1, -1, -1, -1, -1, 1'b0),
            // largest positive lanes: clamp both ways
            row_write(CFG_COL_X, 64'h7FFF_7FFF_7FFF_7FFF),
            row_typed(32767, 0, 0, 0, 32767, 32767, 32767, 32767, 1'b1),
            row_typed(-32768, 0, 0, 0, -32768, -32768, -32768, -32768, 1'b1),
            row_typed(1, 0, 0, 0, 8, 8, 8, 8, 1'b0),
            // most negative lanes
            row_write(CFG_COL_X, 64'h8000_8000_8000_8000),
            row_typed(-32768, 0, 0, 0, 32767, 32767, 32767, 32767, 1'b1),
            row_typed(32767, 0, 0, 0, -32768, -32768, -32768, -32768, 1'b1),
            // smallest lane: exact halves round up
            row_write(CFG_COL_X, 64'h0000_0000_0000_0001),
            row_typed(2048, 0, 0, 0, 1, 0, 0, 0, 1'b0),
            row_typed(2047, 0, 0, 0, 0, 0, 0, 0, 1'b0),
            row_typed(-2048, 0, 0, 0, 0, 0, 0, 0, 1'b0),
            row_typed(-2049, 0, 0, 0, -1, 0, 0, 0, 1'b0),
            // mixed matrix, all columns in play
            row_write(CFG_COL_Y, 64'h7FFF_8000_0001_FFFF),
            row_vec(123, -4567, 8901, -32768),
            row_write(CFG_COL_Z, 64'h8000_7FFF_FFFF_0001),
            row_write(CFG_COL_TRANS, 64'hFFFF_0800_F800_7FFF),
            row_vec(32767, 32767, 32767, 32767),
            row_vec(-32768, -32768, -32768, -32768),
            row_vec(-1, 1, -2048, 2048),
            row_vec(16384, -16384, 4096, -4096)
        };

        // Hold reset low, then release it
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: write rows wait for the pipe to empty
        foreach (dir_plan[i]) begin
            if (dir_plan[i].is_write) begin
                wait_drained();
                write_column(dir_plan[i].idx, dir_plan[i].col);
            end else begin
                send_vector(dir_plan[i].v, dir_plan[i].typed, dir_plan[i].want);
            end
        end

        // Random phases: new matrix while idle, then a run of vectors
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            vec_burst = (phase % 4 == 1);
            res_burst = (phase % 4 == 2);
            if (phase <= int'(MAT_IDENT)) begin
                mode = t_mat_mode'(phase);
            end else begin
                mode = ($urandom_range(0, 3) == 0) ? t_mat_mode'($urandom_range(1, 5))
                                                   : MAT_SMALL;
            end
            for (c = 0; c < NUM_COLS; c++) begin
                write_column(t_cfg_idx'(c), random_column(mode, c));
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                v.x = random_component();
                v.y = random_component();
                v.z = random_component();
                v.w = random_component();
                send_vector(v, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
